// File: rtl/core/scascii_pkg.sv
// ----------------------------------------------------------------------------
// scascii_pkg
// Shared types, constants and key tables for the scan-code translator.
// ----------------------------------------------------------------------------
package scascii_pkg;

    localparam int SCANCODE_W = 8;
    localparam int KEY_CODE_W = 9;
    localparam int LED_W      = 3;

    typedef logic [SCANCODE_W-1:0] scancode_t;
    typedef logic [KEY_CODE_W-1:0] key_code_t;
    typedef logic [LED_W-1:0]      led_t;
    typedef logic [6:0]            make_t;

    localparam key_code_t KEY_NONE = 9'd0;
    localparam key_code_t KEY_BASE = 9'd300;
    localparam key_code_t KEY_BS   = 9'd301;
    localparam key_code_t KEY_EN   = 9'd302;
    localparam key_code_t KEY_F1   = 9'd303;
    localparam key_code_t KEY_TAB  = 9'd313;

    localparam led_t LED_CAPS   = 3'd4;
    localparam led_t LED_NUM    = 3'd2;
    localparam led_t LED_SCROLL = 3'd1;
    localparam led_t LED_RESET  = LED_NUM;

    localparam scancode_t SC_CAPS_LOCK   = 8'd58;
    localparam scancode_t SC_NUM_LOCK    = 8'd69;
    localparam scancode_t SC_SCROLL_LOCK = 8'd70;
    localparam scancode_t SC_LSHIFT_MAKE = 8'h2a;
    localparam scancode_t SC_RSHIFT_MAKE = 8'h36;
    localparam scancode_t SC_LSHIFT_BRK  = 8'haa;
    localparam scancode_t SC_RSHIFT_BRK  = 8'hb6;

    typedef struct packed {
        key_code_t plain;
        key_code_t shifted;
    } key_pair_t;

    function automatic key_pair_t kp(input logic [7:0] p, input logic [7:0] s);
        key_pair_t r;
        r.plain   = {1'b0, p};
        r.shifted = {1'b0, s};
        return r;
    endfunction

    function automatic key_pair_t kk(input key_code_t k);
        key_pair_t r;
        r.plain   = k;
        r.shifted = k;
        return r;
    endfunction

    function automatic key_code_t key_lookup(input make_t code, input logic shift);
        key_pair_t e;
        unique case (code)
            7'd2:    e = kp("1", "!");
            7'd3:    e = kp("2", "@");
            7'd4:    e = kp("3", "#");
            7'd5:    e = kp("4", "$");
            7'd6:    e = kp("5", "%");
            7'd7:    e = kp("6", "^");
            7'd8:    e = kp("7", "&");
            7'd9:    e = kp("8", "*");
            7'd10:   e = kp("9", "(");
            7'd11:   e = kp("0", ")");
            7'd13:   e = kp("=", "+");
            7'd14:   e = kk(KEY_BS);
            7'd15:   e = kk(KEY_TAB);
            7'd16:   e = kp("q", "Q");
            7'd17:   e = kp("w", "W");
            7'd18:   e = kp("e", "E");
            7'd19:   e = kp("r", "R");
            7'd20:   e = kp("t", "T");
            7'd21:   e = kp("y", "Y");
            7'd22:   e = kp("u", "U");
            7'd23:   e = kp("i", "I");
            7'd24:   e = kp("o", "O");
            7'd25:   e = kp("p", "P");
            7'd26:   e = kp("[", "{");
            7'd27:   e = kp("]", "}");
            7'd28:   e = kk(KEY_EN);
            7'd30:   e = kp("a", "A");
            7'd31:   e = kp("s", "S");
            7'd32:   e = kp("d", "D");
            7'd33:   e = kp("f", "F");
            7'd34:   e = kp("g", "G");
            7'd35:   e = kp("h", "H");
            7'd36:   e = kp("j", "J");
            7'd37:   e = kp("k", "K");
            7'd38:   e = kp("l", "L");
            7'd43:   e = kp(8'h5c, "|");
            7'd44:   e = kp("z", "Z");
            7'd45:   e = kp("x", "X");
            7'd46:   e = kp("c", "C");
            7'd47:   e = kp("v", "V");
            7'd48:   e = kp("b", "B");
            7'd49:   e = kp("n", "N");
            7'd50:   e = kp("m", "M");
            7'd53:   e = kp("/", "?");
            7'd57:   e = kp(" ", " ");
            7'd59:   e = kk(KEY_F1);
            7'd60:   e = kk(KEY_F1 + 9'd1);
            7'd61:   e = kk(KEY_F1 + 9'd2);
            7'd62:   e = kk(KEY_F1 + 9'd3);
            7'd63:   e = kk(KEY_F1 + 9'd4);
            7'd64:   e = kk(KEY_F1 + 9'd5);
            7'd65:   e = kk(KEY_F1 + 9'd6);
            7'd66:   e = kk(KEY_F1 + 9'd7);
            7'd67:   e = kk(KEY_F1 + 9'd8);
            7'd68:   e = kk(KEY_F1 + 9'd9);
            7'd122:  e = kp("/", "/");
            default: e = kk(KEY_NONE);
        endcase
        return shift ? e.shifted : e.plain;
    endfunction

endpackage

// File: rtl/core/scancode_to_ascii_translator_unit.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_translator_unit
// Set 1 scan-code translator with shift tracking and lock LED state.
// ----------------------------------------------------------------------------
// Path: each accepted input beat goes to the input register, then the result register.
// Throughput: one beat per cycle while out_stall is low, set by the single
// lookup stage between the input register and the result register.
// Reset: shift keys released, lock LEDs at num lock on, both stages empty.
// ----------------------------------------------------------------------------
module scancode_to_ascii_translator_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  scascii_pkg::scancode_t      scancode,
    output logic                        out_valid,
    input  logic                        out_stall,
    output scascii_pkg::key_code_t      key_code,
    output scascii_pkg::led_t           led_bits,
    output logic                        led_update
);
    import scascii_pkg::*;

    logic      s1_valid_reg;
    scancode_t code_reg;
    logic      out_valid_reg;
    key_code_t key_code_reg;
    led_t      leds_reg;
    logic      update_reg;
    logic      lshift_reg;
    logic      rshift_reg;

    logic      s2_free;
    logic      advance;
    logic      in_take;
    led_t      leds_next;
    logic      update_next;
    logic      lshift_next;
    logic      rshift_next;
    key_code_t key_code_next;

    assign s2_free  = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && s2_free;
    assign in_stall = s1_valid_reg && !s2_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        leds_next   = leds_reg;
        update_next = 1'b0;
        priority if (code_reg == SC_CAPS_LOCK)
        begin
            leds_next   = leds_reg ^ LED_CAPS;
            update_next = 1'b1;
        end
        else if (code_reg == SC_NUM_LOCK)
        begin
            leds_next   = leds_reg ^ LED_NUM;
            update_next = 1'b1;
        end
        else if (code_reg == SC_SCROLL_LOCK)
        begin
            leds_next   = leds_reg ^ LED_SCROLL;
            update_next = 1'b1;
        end
        else
        begin
            leds_next = leds_reg;
        end

        lshift_next = lshift_reg;
        rshift_next = rshift_reg;
        priority if (code_reg == SC_LSHIFT_MAKE)
            lshift_next = 1'b1;
        else if (code_reg == SC_RSHIFT_MAKE)
            rshift_next = 1'b1;
        else if (code_reg == SC_LSHIFT_BRK)
            lshift_next = 1'b0;
        else if (code_reg == SC_RSHIFT_BRK)
            rshift_next = 1'b0;
        else
            lshift_next = lshift_reg;

        if (code_reg[7])
            key_code_next = KEY_NONE;
        else
            key_code_next = key_lookup(code_reg[6:0], lshift_next || rshift_next);
    end

    // hold the input beat until the result stage frees up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            code_reg <= scancode;
        end
    end

    // advance key state and the result together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            leds_reg      <= LED_RESET;
            lshift_reg    <= 1'b0;
            rshift_reg    <= 1'b0;
        end
        else
        begin
            if (s2_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (advance)
            begin
                leds_reg   <= leds_next;
                lshift_reg <= lshift_next;
                rshift_reg <= rshift_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            key_code_reg <= key_code_next;
            update_reg   <= update_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign key_code   = key_code_reg;
    assign led_bits   = leds_reg;
    assign led_update = update_reg;

    a_lock_no_key : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && update_reg |-> key_code_reg == KEY_NONE)
        else $error("lock key beat carries a key code");

    a_lock_toggles : assert property (@(posedge clk) disable iff (!rst_n)
        advance && update_next |=> leds_reg != $past(leds_reg))
        else $error("lock key beat left the LEDs unchanged");

    a_leds_steady : assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(leds_reg) && $stable(lshift_reg) && $stable(rshift_reg))
        else $error("key state moved without a beat");

    a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with a free stage");

endmodule
